// File: rtl/core/fmsh_pkg.sv
// shared types, constants and fold arithmetic for the folded multiply sponge hasher
package fmsh_pkg;

	localparam logic [63:0] SEED_ACC  = 64'h243f6a8885a308d3;
	localparam logic [63:0] MIX_SEED  = 64'h13198a2e03707344;
	localparam int SPONGE_BITS = 128;
	localparam int WORD_BITS   = 64;

	localparam logic [1:0] MODE_ABSORB  = 2'd0;
	localparam logic [1:0] MODE_FINISH  = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// four 32x32 partial products of one 64x64 multiply
	typedef struct packed {
		logic [63:0] p00;
		logic [63:0] p01;
		logic [63:0] p10;
		logic [63:0] p11;
	} prod_t;

	function automatic logic [63:0] mul32(input logic [31:0] x, input logic [31:0] y);
		mul32 = 64'(x) * 64'(y);
	endfunction

	function automatic prod_t fold_parts(input logic [63:0] a, input logic [63:0] b);
		prod_t p;
		p.p00 = mul32(a[31:0], b[31:0]);
		p.p01 = mul32(a[31:0], b[63:32]);
		p.p10 = mul32(a[63:32], b[31:0]);
		p.p11 = mul32(a[63:32], b[63:32]);
		return p;
	endfunction

	// high half of the product xor low half
	function automatic logic [63:0] fold_combine(input prod_t p);
		logic [63:0] mid;
		logic [63:0] lo;
		logic [63:0] hi;
		mid = {32'd0, p.p00[63:32]} + {32'd0, p.p01[31:0]} + {32'd0, p.p10[31:0]};
		lo  = {mid[31:0], p.p00[31:0]};
		hi  = p.p11 + {32'd0, p.p01[63:32]} + {32'd0, p.p10[63:32]} + {32'd0, mid[63:32]};
		return lo ^ hi;
	endfunction

endpackage

// File: rtl/core/folded_multiply_sponge_hash.sv
// streaming integer hasher: 128-bit sponge folded into a 64-bit accumulator by multiply
//
//  channel  signals                                    direction
//  item     item_valid, item_ready, mode, value,       in
//           byte_count
//  result   result_valid, result_ready, hash_value     out
//
// one item per cycle while nothing stalls; a finish directly behind an absorb that folds
// waits while the accumulator's partial products are summed after the multiply
// the four 32x32 multipliers sit between the item register and the product registers;
// a finish passes from the item register through the product register into the result register
// reset returns the accumulator to its seed and empties the sponge
// a stalled result backs up through the product stage into the item register
module folded_multiply_sponge_hash import fmsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  mode,
	input  logic [63:0] value,
	input  logic [3:0]  byte_count,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [63:0] hash_value
);

	// item register
	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [63:0] value_s1;
	logic [3:0]  count_s1;

	// hash state
	logic [63:0] acc_q;
	logic [63:0] low_q;
	logic [63:0] high_q;
	logic [7:0]  fill_q;
	logic        pend_q;
	prod_t       fold_pp_q;

	// result path
	logic        valid_s2;
	prod_t       pp_s2;
	logic        out_valid_q;
	logic [63:0] hash_q;

	logic [3:0]   nbytes;
	logic [6:0]   bits;
	logic [63:0]  vm;
	logic [8:0]   fill_sum;
	logic         overflow;
	logic [127:0] placed;
	logic [63:0]  op_a;
	logic [63:0]  op_b;
	prod_t        prod;
	logic         is_finish;
	logic         needs_acc;
	logic         s1_go;
	logic         s2_ready;
	logic         s3_ready;

	always_comb begin
		if (count_s1 == 4'd0) begin
			nbytes = 4'd1;
		end else if (count_s1 > 4'd8) begin
			nbytes = 4'd8;
		end else begin
			nbytes = count_s1;
		end
		bits = {nbytes, 3'b000};
		for (int i = 0; i < 8; i++) begin
			vm[8*i +: 8] = (4'(i) < nbytes) ? value_s1[8*i +: 8] : 8'd0;
		end
	end

	assign fill_sum = {1'b0, fill_q} + 9'(bits);
	assign overflow = fill_sum > 9'(SPONGE_BITS);
	// fill stays below 128 whenever no fold is needed
	assign placed   = {64'd0, vm} << fill_q[6:0];

	assign is_finish = (mode_s1 == MODE_FINISH);

	// an empty sponge on finish gives acc * 1, whose fold is acc itself
	always_comb begin
		if (is_finish && fill_q == 8'd0) begin
			op_a = acc_q;
			op_b = 64'd1;
		end else begin
			op_a = low_q ^ acc_q;
			op_b = high_q ^ MIX_SEED;
		end
	end

	assign prod = fold_parts(op_a, op_b);

	assign needs_acc = is_finish || (mode_s1 == MODE_ABSORB && overflow);
	assign s3_ready  = !out_valid_q || result_ready;
	assign s2_ready  = !valid_s2 || s3_ready;
	assign s1_go     = valid_s1 && !(needs_acc && pend_q) && (!is_finish || s2_ready);
	assign item_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			mode_s1  <= mode;
			value_s1 <= value;
			count_s1 <= byte_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= SEED_ACC;
			low_q  <= 64'd0;
			high_q <= 64'd0;
			fill_q <= 8'd0;
			pend_q <= 1'b0;
		end else begin
			// a fold's product lands in the accumulator in the cycle after the fold, unless a restart wins
			if (pend_q && !(s1_go && mode_s1 == MODE_RESTART)) begin
				acc_q  <= fold_combine(fold_pp_q);
				pend_q <= 1'b0;
			end
			if (s1_go) begin
				case (mode_s1)
					MODE_ABSORB: begin
						if (overflow) begin
							pend_q <= 1'b1;
							low_q  <= vm;
							high_q <= 64'd0;
							fill_q <= {1'b0, bits};
						end else begin
							low_q  <= low_q | placed[63:0];
							high_q <= high_q | placed[127:64];
							fill_q <= fill_sum[7:0];
						end
					end
					MODE_RESTART: begin
						acc_q  <= SEED_ACC;
						low_q  <= 64'd0;
						high_q <= 64'd0;
						fill_q <= 8'd0;
						pend_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && mode_s1 == MODE_ABSORB && overflow) begin
			fold_pp_q <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= s1_go && is_finish;
			end
			if (s3_ready) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && is_finish) begin
			pp_s2 <= prod;
		end
		if (valid_s2 && s3_ready) begin
			hash_q <= fold_combine(pp_s2);
		end
	end

	assign result_valid = out_valid_q;
	assign hash_value   = hash_q;

	// the fill after a fold is at most 64, so two folds never come back to back
	a_pend_single: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> !pend_q)
		else $error("accumulator product pending for two cycles");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= 8'(SPONGE_BITS)) && (fill_q[2:0] == 3'd0))
		else $error("sponge fill out of range or not byte aligned");

	a_finish_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && needs_acc) |-> !pend_q)
		else $error("accumulator read while its product is pending");

	a_finish_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && is_finish) |=> valid_s2)
		else $error("finish request lost before the product stage");

endmodule

// File: tb/sv/folded_multiply_sponge_hash_tb.sv
// testbench for the folded multiply sponge hasher: shadow model, random traffic, result checks
`timescale 1ns / 100ps

module folded_multiply_sponge_hash_tb import fmsh_pkg::*;;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [1:0]  mode = MODE_ABSORB;
	logic [63:0] value = 64'd0;
	logic [3:0]  byte_count = 4'd1;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [63:0] hash_value;

	// shadow copy of the hasher state
	logic [63:0]  shadow_acc;
	logic [127:0] shadow_sponge;
	int unsigned  shadow_fill;

	logic [63:0] expected_digests[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	folded_multiply_sponge_hash dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.mode(mode),
		.value(value),
		.byte_count(byte_count),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.hash_value(hash_value)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// full 128-bit product, high half xor low half
	function automatic logic [63:0] fold_digest(input logic [63:0] acc, input logic [127:0] sponge);
		logic [127:0] prod;
		prod = {64'd0, sponge[63:0] ^ acc} * {64'd0, sponge[127:64] ^ MIX_SEED};
		return prod[127:64] ^ prod[63:0];
	endfunction

	task automatic reset_shadow_hasher();
		shadow_acc = SEED_ACC;
		shadow_sponge = 128'd0;
		shadow_fill = 0;
	endtask

	task automatic advance_shadow_hasher(input logic [1:0] m, input logic [63:0] v,
			input logic [3:0] bc);
		int unsigned nbytes;
		int unsigned bits;
		logic [63:0] word;
		case (m)
			MODE_RESTART: begin
				reset_shadow_hasher();
			end
			MODE_FINISH: begin
				if (shadow_fill != 0)
					expected_digests.push_back(fold_digest(shadow_acc, shadow_sponge));
				else
					expected_digests.push_back(shadow_acc);
			end
			MODE_ABSORB: begin
				nbytes = (bc == 0) ? 1 : ((bc > 8) ? 8 : bc);
				bits = nbytes * 8;
				word = v;
				if (bits < WORD_BITS)
					word = v & ((64'd1 << bits) - 64'd1);
				if (shadow_fill + bits > SPONGE_BITS) begin
					shadow_acc = fold_digest(shadow_acc, shadow_sponge);
					shadow_sponge = {64'd0, word};
					shadow_fill = bits;
				end else begin
					shadow_sponge = shadow_sponge | ({64'd0, word} << shadow_fill);
					shadow_fill = shadow_fill + bits;
				end
			end
			default: begin
				// unused mode leaves everything alone
			end
		endcase
	endtask

	// returns right after the edge that accepted the request, valid still high
	task automatic send_item(input logic [1:0] m, input logic [63:0] v, input logic [3:0] bc);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		value <= v;
		byte_count <= bc;
		do
			@(posedge clk);
		while (!item_ready);
		advance_shadow_hasher(m, v, bc);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_digests.size() == 0) begin
				$display("%0t unexpected hash_value: expected none, got %h", $time, hash_value);
				error_count <= error_count + 1;
			end else begin
				if (hash_value !== expected_digests[0]) begin
					$display("%0t hash_value mismatch: expected %h, got %h",
						$time, expected_digests[0], hash_value);
					error_count <= error_count + 1;
				end
				void'(expected_digests.pop_front());
			end
		end
	end

	task automatic test_field_extremes();
		send_item(MODE_FINISH, 64'd0, 4'd1);
		send_item(MODE_ABSORB, 64'hffff_ffff_ffff_ffff, 4'd8);
		send_item(MODE_FINISH, 64'hffff_ffff_ffff_ffff, 4'd15);
		// byte count zero acts as one byte, above eight saturates
		send_item(MODE_ABSORB, 64'hffff_ffff_ffff_ffff, 4'd0);
		send_item(MODE_ABSORB, 64'hffff_ffff_ffff_ffff, 4'd15);
		send_item(MODE_FINISH, 64'd0, 4'd0);
		send_item(MODE_UNUSED, 64'hffff_ffff_ffff_ffff, 4'd8);
		send_item(MODE_FINISH, 64'd0, 4'd1);
		send_item(MODE_RESTART, 64'hffff_ffff_ffff_ffff, 4'd15);
		send_item(MODE_FINISH, 64'd0, 4'd1);
	endtask

	task automatic test_fill_boundaries();
		send_item(MODE_ABSORB, 64'h0123_4567_89ab_cdef, 4'd8);
		send_item(MODE_ABSORB, 64'hfedc_ba98_7654_3210, 4'd8);
		send_item(MODE_FINISH, 64'd0, 4'd1);
		// sponge full, the next byte folds and a finish follows right behind
		send_item(MODE_ABSORB, 64'hffff_ffff_ffff_ffa5, 4'd1);
		send_item(MODE_FINISH, 64'd0, 4'd1);
		send_item(MODE_RESTART, 64'd0, 4'd1);
		send_item(MODE_ABSORB, 64'hffff_ffff_ffff_ffff, 4'd7);
		send_item(MODE_ABSORB, 64'hffff_ffff_ffff_ff3c, 4'd1);
		// fill is exactly 64 here, so this lands wholly in the upper half
		send_item(MODE_ABSORB, 64'hffff_ffff_ffff_ffff, 4'd8);
		send_item(MODE_FINISH, 64'd0, 4'd1);
		send_item(MODE_ABSORB, 64'h8000_0000_0000_0001, 4'd3);
		send_item(MODE_FINISH, 64'd0, 4'd1);
		send_item(MODE_RESTART, 64'd0, 4'd1);
	endtask

	task automatic test_random_stream(input int unsigned n_items, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int unsigned pick;
		logic [1:0]  m;
		logic [63:0] v;
		logic [3:0]  bc;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int unsigned i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			if (pick < 72)
				m = MODE_ABSORB;
			else if (pick < 92)
				m = MODE_FINISH;
			else if (pick < 97)
				m = MODE_RESTART;
			else
				m = MODE_UNUSED;
			pick = $urandom_range(99);
			if (pick < 6)
				v = 64'd0;
			else if (pick < 12)
				v = 64'hffff_ffff_ffff_ffff;
			else
				v = {$urandom, $urandom};
			pick = $urandom_range(99);
			if (pick < 88)
				bc = 4'($urandom_range(8, 1));
			else if (pick < 93)
				bc = 4'd0;
			else
				bc = 4'($urandom_range(15, 9));
			send_item(m, v, bc);
		end
	endtask

	initial begin
		reset_shadow_hasher();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_fill_boundaries();
		test_random_stream(440, 0, 0);
		test_random_stream(440, 51, 0);
		test_random_stream(440, 0, 51);
		test_random_stream(440, 37, 37);
		item_valid <= 1'b0;
		while (expected_digests.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_digests.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
